// ----- sv/transposition_table_probe_store_macros.svh -----
// ----------------------------------------------------------------------------
// Transposition table probe store: assertion macros
// Shared assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpt assertion failed");

// antecedent implies consequent in the next cycle
`define TPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpt assertion failed");

`endif

// ----- sv/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Transposition table package
// Types, sizes and score helpers shared by the table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

    localparam int ENTRIES   = 65536;
    localparam int MAX_DEPTH = 128;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int DEPTH_CAP = (MAX_DEPTH - 1 < 127) ? MAX_DEPTH - 1 : 127;

    localparam logic [14:0] MATE_TH_RESET = 15'd31000;

    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] BND_UPPER = 2'd0;
    localparam logic [1:0] BND_LOWER = 2'd1;
    localparam logic [1:0] BND_EXACT = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        key;
        logic [31:0]        move_in;
        logic signed [15:0] score_in;
        logic [1:0]         bound_in;
        logic [6:0]         depth_in;
        logic [6:0]         ply;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [31:0]        move_out;
        logic signed [15:0] score_out;
        logic               score_valid;
        logic               usable;
    } t_out_item;

    typedef struct packed {
        logic [63:0]        key;
        logic [31:0]        move;
        logic signed [16:0] score;
        logic [6:0]         depth;
        logic [1:0]         bound;
    } t_slot;

    typedef enum logic {
        ST_SWEEP,
        ST_READY
    } t_state;

    typedef struct packed {
        logic              busy;
        logic              we;
        logic [ADDR_W-1:0] addr;
    } t_sweep;

    // mate scores move away from zero by ply on store
    function automatic logic signed [16:0] store_score(
        input logic signed [15:0] s,
        input logic [6:0]         ply,
        input logic [14:0]        th
    );
        logic signed [16:0] se;
        logic signed [16:0] th_s;
        logic signed [16:0] p;
        se   = {s[15], s};
        th_s = {2'b00, th};
        p    = {10'd0, ply};
        if (se >= th_s) begin
            return se + p;
        end else if (se <= -th_s) begin
            return se - p;
        end
        return se;
    endfunction

    // undo the mate adjustment, then saturate to +/-32767
    function automatic logic signed [15:0] probe_score(
        input logic signed [16:0] s,
        input logic [6:0]         ply,
        input logic [14:0]        th
    );
        logic signed [17:0] se;
        logic signed [17:0] th_s;
        logic signed [17:0] p;
        logic signed [17:0] a;
        se   = {s[16], s};
        th_s = {3'b000, th};
        p    = {11'd0, ply};
        if (se >= th_s) begin
            a = se - p;
        end else if (se <= -th_s) begin
            a = se + p;
        end else begin
            a = se;
        end
        if (a > 18'sd32767) begin
            return 16'sd32767;
        end else if (a < -18'sd32767) begin
            return -16'sd32767;
        end
        return a[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/tpt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/tpt_clear_seq.sv -----
// ----------------------------------------------------------------------------
// Table clear sequencer
// Walks every slot once after reset and after a clear command, writing zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_clear_seq
    import tpt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_clear,
    output t_sweep    o_ctl
);

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            ST_SWEEP: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(ENTRIES - 1)) begin
                    n_state = ST_READY;
                    n_addr  = '0;
                end
            end
            ST_READY: begin
                if (i_clear) begin
                    n_state = ST_SWEEP;
                    n_addr  = '0;
                end
            end
            default: begin
                n_state = ST_SWEEP;
                n_addr  = '0;
            end
        endcase
    end

    always_comb begin
        o_ctl.addr = r_addr;
        case (r_state)
            ST_SWEEP: begin
                o_ctl.busy = 1'b1;
                o_ctl.we   = 1'b1;
            end
            ST_READY: begin
                o_ctl.busy = 1'b0;
                o_ctl.we   = 1'b0;
            end
            default: begin
                o_ctl.busy = 1'b1;
                o_ctl.we   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/tpt_probe_pipe.sv -----
// ----------------------------------------------------------------------------
// Probe result pipeline
// Takes the slot read back from the table and forms the probe result.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_probe_pipe
    import tpt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_probe,
    input  wire t_in_item    i_item,
    input  wire t_slot       i_rd_slot,
    input  wire logic [14:0] i_mate_th,
    output logic             o_strobe,
    output t_out_item        o_result
);

    // stage A: request waits for the RAM read
    logic     r_a_vld;
    t_in_item r_a_req;

    // stage B: key compare and score adjust done
    logic               r_b_vld;
    logic               r_b_hit;
    logic               r_b_valid;
    logic [31:0]        r_b_move;
    logic signed [15:0] r_b_score;
    logic [1:0]         r_b_bound;
    logic signed [15:0] r_b_alpha;
    logic signed [15:0] r_b_beta;

    logic               w_hit;
    logic               w_deep;
    logic signed [15:0] w_score;
    logic               w_usable;

    logic      r_c_vld;
    t_out_item r_c_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_probe;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_probe) begin
            r_a_req <= i_item;
        end
    end

    assign w_hit   = (i_rd_slot.key == r_a_req.key);
    assign w_deep  = (i_rd_slot.depth >= r_a_req.depth_in);
    assign w_score = probe_score(i_rd_slot.score, r_a_req.ply, i_mate_th);

    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_b_hit   <= w_hit;
            r_b_valid <= w_hit && w_deep;
            r_b_move  <= w_hit ? i_rd_slot.move : 32'd0;
            r_b_score <= w_score;
            r_b_bound <= i_rd_slot.bound;
            r_b_alpha <= r_a_req.alpha;
            r_b_beta  <= r_a_req.beta;
        end
    end

    // bound code 3 is never usable
    assign w_usable = r_b_valid
                   && ((r_b_bound == BND_EXACT)
                    || (r_b_bound == BND_UPPER && r_b_score <= r_b_alpha)
                    || (r_b_bound == BND_LOWER && r_b_score >= r_b_beta));

    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_c_res.hit         <= r_b_hit;
            r_c_res.move_out    <= r_b_move;
            r_c_res.score_out   <= r_b_valid ? r_b_score : 16'sd0;
            r_c_res.score_valid <= r_b_valid;
            r_c_res.usable      <= w_usable;
        end
    end

    assign o_strobe = r_c_vld;
    assign o_result = r_c_res;

endmodule

`default_nettype wire

// ----- sv/transposition_table_probe_store.sv -----
// ----------------------------------------------------------------------------
// Transposition table probe store
// Direct-mapped search result table: probe, store and clear commands.
// ----------------------------------------------------------------------------
// Probes and stores are taken one per clock while busy is low. A store
// writes its slot at the transfer edge and gives no result; a probe reads
// its slot from the table RAM and its result shows on o_result with o_strobe
// high for one cycle, after the RAM read, stage B and result register. The
// receiver cannot hold results off, so it must take each one in that cycle.
// A probe right after a store to the same slot sees the new data.
// After reset and after a clear command the table is zeroed one slot per
// cycle with busy high; probes already in flight still complete. The user
// writes mate_threshold (i_cfg_we/i_cfg_wdata) only while idle; unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module transposition_table_probe_store
    import tpt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire t_in_item    i_item,
    input  wire logic        i_cfg_we,
    input  wire logic [14:0] i_cfg_wdata,
    output logic             busy,
    output logic             o_strobe,
    output t_out_item        o_result
);

    logic [14:0]       r_mate_th;
    t_sweep            w_sweep;
    logic              w_acc;
    logic              w_probe;
    logic              w_store;
    logic              w_clear;
    logic [ADDR_W-1:0] w_idx;
    logic [63:0]       w_idx_full;
    logic [6:0]        w_depth;
    t_slot             w_new_slot;
    t_slot             w_wdata;
    t_slot             w_rdata;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_th <= MATE_TH_RESET;
        end else if (i_cfg_we) begin
            r_mate_th <= i_cfg_wdata;
        end
    end

    assign busy    = w_sweep.busy;
    assign w_acc   = start && !w_sweep.busy;
    assign w_probe = w_acc && (i_item.command == CMD_PROBE);
    assign w_store = w_acc && (i_item.command == CMD_STORE);
    assign w_clear = w_acc && (i_item.command == CMD_CLEAR);

    assign w_idx_full = i_item.key & 64'(ENTRIES - 1);
    assign w_idx      = w_idx_full[ADDR_W-1:0];

    assign w_depth = (i_item.depth_in > 7'(DEPTH_CAP)) ? 7'(DEPTH_CAP) : i_item.depth_in;

    always_comb begin
        w_new_slot.key   = i_item.key;
        w_new_slot.move  = i_item.move_in;
        w_new_slot.score = store_score(i_item.score_in, i_item.ply, r_mate_th);
        w_new_slot.depth = w_depth;
        w_new_slot.bound = i_item.bound_in;
    end

    // sweep and store never overlap: no transfer while the sweep runs
    assign w_we    = w_sweep.we || w_store;
    assign w_waddr = w_sweep.we ? w_sweep.addr : w_idx;
    assign w_wdata = w_sweep.we ? t_slot'('0) : w_new_slot;

    tpt_clear_seq u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .o_ctl   (w_sweep)
    );

    tpt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(t_slot))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_probe),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    tpt_probe_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_probe   (w_probe),
        .i_item    (i_item),
        .i_rd_slot (w_rdata),
        .i_mate_th (r_mate_th),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ----- sv/tpt_checker.sv -----
// ----------------------------------------------------------------------------
// Transposition table port checker
// Watches the top-level ports for result timing and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "transposition_table_probe_store_macros.svh"

module tpt_checker
    import tpt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire t_in_item  i_item,
    input wire logic      busy,
    input wire logic      o_strobe,
    input wire t_out_item o_result
);

    logic w_probe_xfer;
    logic w_clear_xfer;

    assign w_probe_xfer = i_rst_n && start && !busy && (i_item.command == CMD_PROBE);
    assign w_clear_xfer = i_rst_n && start && !busy && (i_item.command == CMD_CLEAR);

    `TPT_ASSERT_IMPL(a_strobe_from_probe, i_clk, i_rst_n, o_strobe, $past(w_probe_xfer, 3))
    `TPT_ASSERT_IMPL(a_probe_gives_result, i_clk, i_rst_n, $past(w_probe_xfer, 3), o_strobe)
    `TPT_ASSERT_IMPL(a_miss_is_empty, i_clk, i_rst_n, o_strobe && !o_result.hit, o_result.move_out == 32'd0 && !o_result.score_valid)
    `TPT_ASSERT_IMPL(a_usable_needs_score, i_clk, i_rst_n, o_strobe && !o_result.score_valid, !o_result.usable && o_result.score_out == 16'sd0)
    `TPT_ASSERT_NEXT(a_clear_sets_busy, i_clk, i_rst_n, w_clear_xfer, busy)

endmodule

bind transposition_table_probe_store tpt_checker u_tpt_checker (.*);

`default_nettype wire
